/* design/lrt_pkg.sv */
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared constants and types for the LRU line register tag store.
// ----------------------------------------------------------------------------
package lrt_pkg;

	// Geometry
	localparam int SLOTS    = 8;
	localparam int TAG_BITS = 40;
	localparam int ADDR_W   = 40;
	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int AGE_W    = SLOT_W;
	localparam int OUT_SLOT_W = 3;

	// Oldest age a slot can have
	localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(SLOTS - 1);

	// Request function codes
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// Outcome codes
	typedef enum logic [1:0] {
		OUT_HIT     = 2'd0,
		OUT_MISS    = 2'd1,
		OUT_NO_SLOT = 2'd2
	} outcome_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the request on its transfer
		logic update;   // look up, update slot state, load result
	} lrt_cmd_t;

endpackage

/* design/lrt_ctrl.sv */
// ----------------------------------------------------------------------------
// lrt_ctrl
// Two-state controller: takes a request, then runs the lookup/update in ST_LOOKUP.
// ----------------------------------------------------------------------------
module lrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output lrt_pkg::lrt_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	// Commands to the datapath
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.update  = (state_q == ST_LOOKUP);
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= ST_LOOKUP;
						busy_q  <= 1'b1;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

/* design/lrt_datapath.sv */
// ----------------------------------------------------------------------------
// lrt_datapath
// Slot registers, parallel tag compare, victim pick, age update, result regs.
// ----------------------------------------------------------------------------
module lrt_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lrt_pkg::lrt_cmd_t                     cmd,
	input  logic                                  func,
	input  logic [lrt_pkg::ADDR_W-1:0]            line_addr,
	output logic [1:0]                            outcome,
	output logic [lrt_pkg::OUT_SLOT_W-1:0]        slot,
	output logic                                  evict_valid,
	output logic [lrt_pkg::ADDR_W-1:0]            evict_line_addr,
	output logic                                  fill_valid
);

	localparam int N  = lrt_pkg::SLOTS;
	localparam int SW = lrt_pkg::SLOT_W;
	localparam int AW = lrt_pkg::AGE_W;
	localparam int TW = lrt_pkg::TAG_BITS;

	// Captured request
	logic          req_func_q;
	logic [TW-1:0] req_tag_q;

	// Slot state
	logic [N-1:0]  valid_q;
	logic [N-1:0]  dirty_q;
	logic [TW-1:0] tag_q [N];
	logic [AW-1:0] age_q [N];

	// Result registers
	logic [1:0]                        outcome_q;
	logic [lrt_pkg::OUT_SLOT_W-1:0]    slot_q;
	logic                              evict_valid_q;
	logic [lrt_pkg::ADDR_W-1:0]        evict_addr_q;
	logic                              fill_valid_q;

	// Lookup signals
	logic [N-1:0]  hit_vec;
	logic [N-1:0]  inv_vec;
	logic [N-1:0]  max_vec;
	logic [SW-1:0] hit_idx;
	logic [SW-1:0] inv_idx;
	logic [SW-1:0] max_idx;
	logic          any_hit;
	logic          any_inv;
	logic          any_max;
	logic          no_slot;
	logic          is_write;
	logic          do_young;
	logic [SW-1:0] sel;
	logic [AW-1:0] ref_age;
	logic [N-1:0]  valid_nxt;
	logic          victim_dirty;

	// Request capture on transfer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_func_q <= func;
			req_tag_q  <= TW'(line_addr);
		end
	end

	// Per-slot match flags
	always_comb begin
		for (int i = 0; i < N; i++) begin
			hit_vec[i] = valid_q[i] && (tag_q[i] == req_tag_q);
			inv_vec[i] = !valid_q[i];
			max_vec[i] = (age_q[i] == lrt_pkg::AGE_MAX);
		end
	end

	// Lowest-index priority encoders
	always_comb begin
		hit_idx = '0;
		inv_idx = '0;
		max_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_idx = SW'(i);
			if (inv_vec[i]) inv_idx = SW'(i);
			if (max_vec[i]) max_idx = SW'(i);
		end
	end

	// Slot selection and ageing reference
	always_comb begin
		any_hit  = |hit_vec;
		any_inv  = |inv_vec;
		any_max  = |max_vec;
		no_slot  = !any_hit && !any_inv && !any_max;
		is_write = (req_func_q == lrt_pkg::FUNC_WRITE);
		do_young = any_hit || is_write;
		if (any_hit) begin
			sel = hit_idx;
		end else if (any_inv) begin
			sel = inv_idx;
		end else begin
			sel = max_idx;
		end
		ref_age   = any_hit ? age_q[hit_idx] : lrt_pkg::AGE_MAX;
		valid_nxt = valid_q;
		valid_nxt[sel] = 1'b1;
		// an invalid victim is clean, so only a max-age victim can write back
		victim_dirty = !any_hit && !any_inv && dirty_q[sel];
	end

	// Valid, dirty and age state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < N; i++) begin
				age_q[i] <= '0;
			end
		end else if (cmd.update && !no_slot) begin
			valid_q <= valid_nxt;
			dirty_q[sel] <= any_hit ? (dirty_q[sel] || is_write) : is_write;
			for (int i = 0; i < N; i++) begin
				if (do_young) begin
					if (SW'(i) == sel) begin
						age_q[i] <= '0;
					end else if (valid_nxt[i] && (age_q[i] < ref_age)) begin
						age_q[i] <= age_q[i] + AW'(1);
					end
				end else if ((SW'(i) == sel) && any_inv) begin
					// read miss into an empty slot parks at oldest age
					age_q[i] <= lrt_pkg::AGE_MAX;
				end
			end
		end
	end

	// Tag storage: new tag on a miss
	always_ff @(posedge clk) begin
		if (cmd.update && !no_slot && !any_hit) begin
			tag_q[sel] <= req_tag_q;
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (no_slot) begin
				outcome_q     <= lrt_pkg::OUT_NO_SLOT;
				slot_q        <= '0;
				evict_valid_q <= 1'b0;
				evict_addr_q  <= '0;
				fill_valid_q  <= 1'b0;
			end else begin
				outcome_q     <= any_hit ? lrt_pkg::OUT_HIT : lrt_pkg::OUT_MISS;
				slot_q        <= lrt_pkg::OUT_SLOT_W'(sel);
				evict_valid_q <= victim_dirty;
				evict_addr_q  <= victim_dirty ? lrt_pkg::ADDR_W'(tag_q[sel]) : '0;
				fill_valid_q  <= !any_hit && !is_write;
			end
		end
	end

	assign outcome         = outcome_q;
	assign slot            = slot_q;
	assign evict_valid     = evict_valid_q;
	assign evict_line_addr = evict_addr_q;
	assign fill_valid      = fill_valid_q;

endmodule

/* design/lru_line_register_tag_store.sv */
// ----------------------------------------------------------------------------
// lru_line_register_tag_store
// Fully associative LRU write-back tag store over a small set of line regs.
// ----------------------------------------------------------------------------
// Result strobe (done) is registered and set with the result registers as ST_LOOKUP ends.
// A new request is taken only in ST_IDLE; busy is high for the lookup
//   cycle, in which tag compare, victim pick and age update run over all slots.
// The receiver cannot stall: done is high for one cycle only; results hold until the next lookup.
// Reset (arst_n low): all slots invalid, clean, age zero; no pending request.
// ----------------------------------------------------------------------------
module lru_line_register_tag_store (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               func,
	input  logic [lrt_pkg::ADDR_W-1:0]         line_addr,
	output logic                               done,
	output logic [1:0]                         outcome,
	output logic [lrt_pkg::OUT_SLOT_W-1:0]     slot,
	output logic                               evict_valid,
	output logic [lrt_pkg::ADDR_W-1:0]         evict_line_addr,
	output logic                               fill_valid
);

	lrt_pkg::lrt_cmd_t cmd;

	// Sequencer
	lrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Slot array and result registers
	lrt_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.func            (func),
		.line_addr       (line_addr),
		.outcome         (outcome),
		.slot            (slot),
		.evict_valid     (evict_valid),
		.evict_line_addr (evict_line_addr),
		.fill_valid      (fill_valid)
	);

endmodule
